// ----- hdl/lds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LOOK disk request scheduler package
// Shared widths, default sizes and the operation and status codes.
// ----------------------------------------------------------------------------
package lds_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int TRACK_BITS_DEFAULT = 15;
   localparam int TAG_BITS           = 8;
   localparam int STATUS_BITS        = 2;

   typedef enum logic {
      OP_ENQUEUE  = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_ACCEPTED   = 2'd0,
      STATUS_DISPATCHED = 2'd1,
      STATUS_FULL       = 2'd2,
      STATUS_EMPTY      = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ----- hdl/look_disk_request_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LOOK disk request scheduler
// Keeps a table of pending requests in arrival order and hands them out in
// LOOK order, scanning the table with one comparator.
// ----------------------------------------------------------------------------
// Usage: drive req_op, req_track and req_tag and raise start while busy is low
// to hand over one beat. Each beat yields exactly one response beat, shown on
// the rsp_ ports for a single cycle while rsp_valid is high.
// An enqueue answers in the cycle after it is taken and leaves busy low, so
// enqueues may follow in every cycle. A dispatch with nothing pending answers
// the same way.
// A dispatch scans the table through a single memory read port and one
// subtract-and-compare unit, one entry per cycle; each pass reads every entry
// and then settles the choice, and a second pass follows when nothing lies
// ahead in the current direction and more than one entry is pending. The
// response leaves at the end of the scan; the table then closes the gap left
// by the removed entry, one entry per cycle.
// Reset empties the table, moves the head to track zero and sets the sweep
// upward. The receiver cannot stall; responses are never held back.
// ----------------------------------------------------------------------------
module look_disk_request_scheduler
   import lds_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int TRACK_BITS = TRACK_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_op,
   input  wire logic [TRACK_BITS-1:0]  req_track,
   input  wire logic [TAG_BITS-1:0]    req_tag,
   output logic                        rsp_valid,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [TAG_BITS-1:0]         rsp_out_tag,
   output logic [TRACK_BITS-1:0]       rsp_out_track
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [TRACK_BITS-1:0]   head_ff, head_in;
   logic                    down_ff, down_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic                    pipe_vld_ff, pipe_vld_in;
   logic [CNT_W-1:0]        pipe_idx_ff, pipe_idx_in;
   logic                    found_ff, found_in;
   logic                    second_ff, second_in;
   logic [TRACK_BITS-1:0]   best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [TRACK_BITS-1:0]   best_track_ff, best_track_in;
   logic [TAG_BITS-1:0]     best_tag_ff, best_tag_in;
   logic [TRACK_BITS-1:0]   first_track_ff, first_track_in;
   logic [TAG_BITS-1:0]     first_tag_ff, first_tag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [TRACK_BITS-1:0]   rsp_track_ff, rsp_track_in;

   logic [TRACK_BITS-1:0]   mem_track [DEPTH];
   logic [TAG_BITS-1:0]     mem_tag [DEPTH];
   logic [TRACK_BITS-1:0]   rd_track_ff;
   logic [TAG_BITS-1:0]     rd_tag_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [TRACK_BITS-1:0]   mem_wtrack;
   logic [TAG_BITS-1:0]     mem_wtag;

   logic                    issue;
   logic [TRACK_BITS-1:0]   cmp_a;
   logic [TRACK_BITS-1:0]   cmp_b;
   logic                    beyond;
   logic [TRACK_BITS-1:0]   distance;
   logic [CNT_W-1:0]        shift_dst;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_track[mem_waddr] <= mem_wtrack;
         mem_tag[mem_waddr]   <= mem_wtag;
      end
      rd_track_ff <= mem_track[ptr_ff[IDX_W-1:0]];
      rd_tag_ff   <= mem_tag[ptr_ff[IDX_W-1:0]];
   end

   assign issue     = ptr_ff < count_ff;
   assign cmp_a     = down_ff ? head_ff : rd_track_ff;
   assign cmp_b     = down_ff ? rd_track_ff : head_ff;
   assign beyond    = cmp_a > cmp_b;
   assign distance  = cmp_a - cmp_b;
   assign shift_dst = pipe_idx_ff - CNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      down_in        = down_ff;
      ptr_in         = ptr_ff;
      pipe_vld_in    = 1'b0;
      pipe_idx_in    = ptr_ff;
      found_in       = found_ff;
      second_in      = second_ff;
      best_dist_in   = best_dist_ff;
      best_idx_in    = best_idx_ff;
      best_track_in  = best_track_ff;
      best_tag_in    = best_tag_ff;
      first_track_in = first_track_ff;
      first_tag_in   = first_tag_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = '0;
      rsp_track_in   = '0;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[IDX_W-1:0];
      mem_wtrack     = req_track;
      mem_wtag       = req_tag;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     rsp_status_in = STATUS_ACCEPTED;
                     mem_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  state_in  = S_SCAN;
                  ptr_in    = '0;
                  found_in  = 1'b0;
                  second_in = 1'b0;
               end
            end
         end

         S_SCAN: begin
            ptr_in      = issue ? ptr_ff + CNT_W'(1) : ptr_ff;
            pipe_vld_in = issue;
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == '0) begin
                  first_track_in = rd_track_ff;
                  first_tag_in   = rd_tag_ff;
               end
               if (beyond && (!found_ff || distance < best_dist_ff)) begin
                  found_in      = 1'b1;
                  best_dist_in  = distance;
                  best_idx_in   = pipe_idx_ff[IDX_W-1:0];
                  best_track_in = rd_track_ff;
                  best_tag_in   = rd_tag_ff;
               end
            end
            if (!issue && !pipe_vld_ff) begin
               if (count_ff != CNT_W'(1) && !found_ff && !second_ff) begin
                  down_in   = ~down_ff;
                  second_in = 1'b1;
                  ptr_in    = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_DISPATCHED;
                  state_in      = S_SHIFT;
                  if (count_ff != CNT_W'(1) && found_ff) begin
                     rsp_tag_in   = best_tag_ff;
                     rsp_track_in = best_track_ff;
                     head_in      = best_track_ff;
                     ptr_in       = CNT_W'(best_idx_ff) + CNT_W'(1);
                  end else begin
                     rsp_tag_in   = first_tag_ff;
                     rsp_track_in = first_track_ff;
                     head_in      = first_track_ff;
                     ptr_in       = CNT_W'(1);
                  end
               end
            end
         end

         S_SHIFT: begin
            ptr_in      = issue ? ptr_ff + CNT_W'(1) : ptr_ff;
            pipe_vld_in = issue;
            if (pipe_vld_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = shift_dst[IDX_W-1:0];
               mem_wtrack = rd_track_ff;
               mem_wtag   = rd_tag_ff;
            end
            if (!issue && !pipe_vld_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         down_ff      <= 1'b0;
         ptr_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         down_ff      <= down_in;
         ptr_ff       <= ptr_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pipe_idx_ff    <= pipe_idx_in;
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
      best_track_ff  <= best_track_in;
      best_tag_ff    <= best_tag_in;
      first_track_ff <= first_track_in;
      first_tag_ff   <= first_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_track_ff   <= rsp_track_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_out_track = rsp_track_ff;

endmodule
`default_nettype wire

// ----- sim/tb_look_disk_request_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LOOK disk request scheduler testbench
// A short scripted sequence covers the empty and full table, ties, the
// reversal of the sweep and a table whose tracks all sit at the head. Random
// fill and drain episodes follow. The sender works in bursts with random gaps.
// A predictor keeps its own request table, head and sweep direction, and each
// response beat is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_look_disk_request_scheduler;
   import lds_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int TRACK_BITS   = TRACK_BITS_DEFAULT;
   localparam int TRACK_MAX    = (1 << TRACK_BITS) - 1;
   localparam int RANDOM_BEATS = 1400;
   localparam int DRAIN_CYCLES = 64;
   localparam int SCRIPT_ROWS  = 19;

   typedef logic [TRACK_BITS-1:0] track_type;
   typedef logic [TAG_BITS-1:0]   tag_type;

   typedef enum int {
      SPREAD_WIDE,
      SPREAD_LOW,
      SPREAD_NEAR_HEAD,
      SPREAD_EDGES
   } spread_type;

   typedef struct packed {
      status_type status;
      tag_type    tag;
      track_type  track;
   } response_type;

   typedef struct packed {
      op_type       op;
      track_type    track;
      tag_type      tag;
      int           reps;
      int           track_step;
      bit           fixed;
      response_type want;
   } script_row_type;

   script_row_type script_rows [SCRIPT_ROWS] = '{
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b1, '{STATUS_EMPTY,      8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd0,     8'h00, 1,  0,    1'b1, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b1, '{STATUS_DISPATCHED, 8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd32767, 8'hff, 1,  0,    1'b1, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd100,   8'h5a, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd100,   8'ha5, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd0,     8'h11, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd0,     8'h01, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd0,     8'h02, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd1000,  8'h10, 16, 2000, 1'b1, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_ENQUEUE,  15'd7,     8'h07, 1,  0,    1'b1, '{STATUS_FULL,       8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 16, 0,    1'b0, '{STATUS_ACCEPTED,   8'h00, 15'd0}},
      '{OP_DISPATCH, 15'd0,     8'h00, 1,  0,    1'b1, '{STATUS_EMPTY,      8'h00, 15'd0}}
   };

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   req_op    = 1'b0;
   track_type              req_track = '0;
   tag_type                req_tag   = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [STATUS_BITS-1:0] rsp_status;
   tag_type                rsp_out_tag;
   track_type              rsp_out_track;

   track_type    queued_track [DEPTH];
   tag_type      queued_tag [DEPTH];
   int           queued_count  = 0;
   track_type    head_pos      = '0;
   bit           sweeping_down = 1'b0;
   response_type expected_q [$];

   int error_count     = 0;
   int beats_sent      = 0;
   int scripted_beats  = 0;
   int burst_left      = 0;
   int dispatched_seen = 0;
   int full_seen       = 0;
   int empty_seen      = 0;

   look_disk_request_scheduler #(
      .DEPTH      (DEPTH),
      .TRACK_BITS (TRACK_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_track     (req_track),
      .req_tag       (req_tag),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_out_track (rsp_out_track)
   );

   always #5 clock = ~clock;

   function automatic int nearest_pending(bit down);
      int pick = -1;
      int best = 0;
      int distance;
      for (int i = 0; i < queued_count; i++) begin
         if (down && queued_track[i] < head_pos) begin
            distance = int'(head_pos) - int'(queued_track[i]);
         end else if (!down && queued_track[i] > head_pos) begin
            distance = int'(queued_track[i]) - int'(head_pos);
         end else begin
            continue;
         end
         if (pick < 0 || distance < best) begin
            best = distance;
            pick = i;
         end
      end
      return pick;
   endfunction

   function automatic response_type schedule_beat(op_type op, track_type trk, tag_type tg);
      response_type rsp;
      int pick;
      rsp = '{STATUS_ACCEPTED, '0, '0};
      if (op == OP_ENQUEUE) begin
         if (queued_count >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            queued_track[queued_count] = trk;
            queued_tag[queued_count] = tg;
            queued_count++;
         end
      end else if (queued_count == 0) begin
         rsp.status = STATUS_EMPTY;
      end else begin
         pick = 0;
         if (queued_count > 1) begin
            pick = nearest_pending(sweeping_down);
            if (pick < 0) begin
               sweeping_down = !sweeping_down;
               pick = nearest_pending(sweeping_down);
               if (pick < 0) begin
                  pick = 0;
               end
            end
         end
         rsp.status = STATUS_DISPATCHED;
         rsp.tag = queued_tag[pick];
         rsp.track = queued_track[pick];
         head_pos = queued_track[pick];
         for (int i = pick; i < queued_count - 1; i++) begin
            queued_track[i] = queued_track[i + 1];
            queued_tag[i] = queued_tag[i + 1];
         end
         queued_count--;
      end
      return rsp;
   endfunction

   task automatic send_beat(op_type op, track_type trk, tag_type tg, bit fixed,
                            response_type want);
      int gap;
      response_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            req_op <= 1'($urandom);
            req_track <= track_type'($urandom);
            req_tag <= tag_type'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_op <= op;
      req_track <= trk;
      req_tag <= tg;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      predicted = schedule_beat(op, trk, tg);
      expected_q.push_back(fixed ? want : predicted);
      beats_sent++;
   endtask

   task automatic enqueue_random(spread_type spread);
      track_type trk;
      case (spread)
         SPREAD_WIDE: begin
            trk = track_type'($urandom);
         end
         SPREAD_LOW: begin
            trk = track_type'($urandom_range(0, 7));
         end
         SPREAD_NEAR_HEAD: begin
            trk = head_pos + track_type'($urandom_range(0, 6)) - track_type'(3);
         end
         default: begin
            trk = $urandom_range(0, 1) ? track_type'(TRACK_MAX - $urandom_range(0, 2))
                                       : track_type'($urandom_range(0, 2));
         end
      endcase
      send_beat(OP_ENQUEUE, trk, tag_type'($urandom), 1'b0, '0);
   endtask

   initial begin
      spread_type spread;
      int fill;
      int steps;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[r]) begin
         for (int k = 0; k < script_rows[r].reps; k++) begin
            send_beat(script_rows[r].op,
                      script_rows[r].track + track_type'(k * script_rows[r].track_step),
                      script_rows[r].tag + tag_type'(k),
                      script_rows[r].fixed, script_rows[r].want);
         end
      end
      scripted_beats = beats_sent;

      while (beats_sent < scripted_beats + RANDOM_BEATS) begin
         spread = spread_type'($urandom_range(0, 3));
         fill = ($urandom_range(0, 7) == 0) ? DEPTH + $urandom_range(0, 2)
                                            : $urandom_range(1, DEPTH);
         repeat (fill) begin
            enqueue_random(spread);
         end
         steps = queued_count + $urandom_range(0, 4);
         repeat (steps) begin
            if ($urandom_range(0, 3) == 0) begin
               enqueue_random(spread);
            end else begin
               send_beat(OP_DISPATCH, track_type'($urandom), tag_type'($urandom),
                         1'b0, '0);
            end
         end
      end
      start <= 1'b0;

      while (expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response beats: %0d dispatched, %0d table full, %0d empty.",
               beats_sent, dispatched_seen, full_seen, empty_seen);
      $display("The run used %0d scripted beats and %0d random beats.",
               scripted_beats, beats_sent - scripted_beats);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin : response_check
      response_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d tag %0h track %0d",
                     $time, rsp_status, rsp_out_tag, rsp_out_track);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_out_tag !== want.tag) begin
               $display("%0t: tag mismatch, expected %0h, actual %0h",
                        $time, want.tag, rsp_out_tag);
               error_count++;
            end
            if (rsp_out_track !== want.track) begin
               $display("%0t: track mismatch, expected %0d, actual %0d",
                        $time, want.track, rsp_out_track);
               error_count++;
            end
            case (want.status)
               STATUS_DISPATCHED: dispatched_seen++;
               STATUS_FULL:       full_seen++;
               STATUS_EMPTY:      empty_seen++;
               default:           ;
            endcase
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d response beats outstanding.", expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lds_pkg.sv
hdl/look_disk_request_scheduler.sv
sim/tb_look_disk_request_scheduler.sv
